// ===== rtl/core/htd_pkg.sv =====
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types and constants of the Huffman tree decoder: opcodes, result
// status codes, the stage-one kind and the stream widths.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int SYM_W      = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int USER_W     = 2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TREE  = 2'd1,
    OP_MSG   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_SYMBOL     = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_MALFORMED  = 2'd2
  } status_t;

  typedef enum logic {
    S1_RESULT = 1'b0,
    S1_WALK   = 1'b1
  } s1_kind_t;

endpackage

// ===== rtl/core/huffman_tree_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Huffman decoder: builds a decoding tree from a preorder shape stream and
// walks it with message bits, one node-table read per bit.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | tuser: opcode; tdata: bit_value, symbol
//  m_*      | out | m_tvalid/m_tready  | tuser: status; tdata: symbol_out
//
//  one item per cycle while s_tready is high; a result passes the stage-one
//  register and the output queue to m_*; walk rate is set by the child-pointer
//  read: its registered data picks the next read address in the same cycle
//  rst clears all control state at once; the node table needs no clearing pass
//  s_tready drops only when the four-entry output queue could overflow
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
  parameter int MAX_NODES   = 512,
  parameter int STACK_DEPTH = 256,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [htd_pkg::IN_DATA_W-1:0]  s_tdata,   // bit_value, symbol
  input  logic [htd_pkg::USER_W-1:0]     s_tuser,   // opcode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [htd_pkg::OUT_DATA_W-1:0] m_tdata,   // symbol_out
  output logic [htd_pkg::USER_W-1:0]     m_tuser    // status
);

  localparam int NAW     = $clog2(MAX_NODES);
  localparam int NCW     = $clog2(MAX_NODES + 1);
  localparam int SPW     = $clog2(STACK_DEPTH + 1);
  localparam int SAW     = $clog2(STACK_DEPTH);
  localparam int SYM_W   = htd_pkg::SYM_W;
  localparam int CVW     = (NAW > SYM_W) ? NAW : SYM_W;
  localparam int Q_DEPTH = 4;
  localparam int QAW     = 2;
  localparam logic [SYM_W-1:0] SYM_MASK = SYM_W'((1 << SYMBOL_BITS) - 1);

  // child field: leaf flag on top, then node index or leaf symbol
  typedef logic [CVW:0] child_t;

  // node table split by child slot
  child_t         node_zero [MAX_NODES];
  child_t         node_one  [MAX_NODES];
  logic [NAW-1:0] stack_mem [STACK_DEPTH];

  htd_pkg::opcode_t in_op;
  logic             in_bit;
  logic [SYM_W-1:0] in_sym;
  logic             s_fire;
  logic             m_fire;

  logic [NCW-1:0]   node_count, node_count_next;
  logic [SPW-1:0]   sp, sp_next, sp_pop, stk_raddr_full, stk_waddr_full;
  logic             complete, complete_next;
  logic             root_leaf, root_leaf_next;
  logic [SYM_W-1:0] root_sym, root_sym_next;
  logic [NAW-1:0]   walk, walk_next, walk_cur;
  logic [NAW-1:0]   top_idx, top_idx_next;
  logic             top_slot, top_slot_next;
  logic             fwd_valid;
  logic [NAW-1:0]   fwd_idx, second, stk_rd;
  logic             link, pop;

  logic             zero_we, one_we, stk_we;
  child_t           node_wdata, rd_zero, rd_one, s1_child;

  logic                s1_valid, s1_valid_next;
  htd_pkg::s1_kind_t   s1_kind, s1_kind_next;
  logic                s1_bit;
  logic [SYM_W-1:0]    s1_sym, s1_sym_next;
  htd_pkg::status_t    s1_status, s1_status_next;

  logic                res_valid;
  logic [SYM_W-1:0]    res_sym;
  htd_pkg::status_t    res_status;

  logic [SYM_W-1:0]          q_sym    [Q_DEPTH];
  logic [htd_pkg::USER_W-1:0] q_status [Q_DEPTH];
  logic [QAW-1:0]            wr_ptr, rd_ptr;
  logic [QAW:0]              q_count;

  assign in_op  = htd_pkg::opcode_t'(s_tuser);
  assign in_bit = s_tdata[0];
  assign in_sym = s_tdata[SYM_W:1];
  assign s_fire = s_tvalid & s_tready;
  assign m_fire = m_tvalid & m_tready;

  assign s_tready = ((QAW + 2)'(q_count) + (QAW + 2)'(s1_valid)) < (QAW + 2)'(Q_DEPTH);
  assign m_tvalid = (q_count != '0);
  assign m_tdata  = {(htd_pkg::OUT_DATA_W - SYM_W)'(0), q_sym[rd_ptr]};
  assign m_tuser  = q_status[rd_ptr];

  assign second = fwd_valid ? fwd_idx : stk_rd;

  // stage one: finish the walk step or pass a ready result
  always_comb begin
    s1_child   = s1_bit ? rd_one : rd_zero;
    res_valid  = 1'b0;
    res_sym    = '0;
    res_status = htd_pkg::ST_SYMBOL;
    walk_cur   = walk;
    if (s1_valid) begin
      case (s1_kind)
        htd_pkg::S1_RESULT: begin
          res_valid  = 1'b1;
          res_sym    = s1_sym;
          res_status = s1_status;
        end
        htd_pkg::S1_WALK: begin
          if (s1_child[CVW]) begin
            res_valid = 1'b1;
            res_sym   = s1_child[SYM_W-1:0];
            walk_cur  = '0;
          end else begin
            walk_cur  = s1_child[NAW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // stage zero: tree building and message dispatch
  always_comb begin
    node_count_next = node_count;
    sp_next         = sp;
    complete_next   = complete;
    root_leaf_next  = root_leaf;
    root_sym_next   = root_sym;
    walk_next       = walk_cur;
    top_idx_next    = top_idx;
    top_slot_next   = top_slot;
    zero_we         = 1'b0;
    one_we          = 1'b0;
    stk_we          = 1'b0;
    node_wdata      = '0;
    s1_valid_next   = 1'b0;
    s1_kind_next    = htd_pkg::S1_RESULT;
    s1_sym_next     = '0;
    s1_status_next  = htd_pkg::ST_SYMBOL;
    link            = (node_count != '0);
    pop             = link & top_slot;
    sp_pop          = sp - SPW'(pop);
    if (s_fire) begin
      case (in_op)
        htd_pkg::OP_START: begin
          node_count_next = '0;
          sp_next         = '0;
          complete_next   = 1'b0;
          root_leaf_next  = 1'b0;
          walk_next       = '0;
        end
        htd_pkg::OP_TREE: begin
          if (complete || (node_count >= NCW'(MAX_NODES)) ||
              (in_bit && (sp_pop >= SPW'(STACK_DEPTH)))) begin
            s1_valid_next  = 1'b1;
            s1_status_next = htd_pkg::ST_MALFORMED;
          end else begin
            node_wdata = in_bit ? {1'b0, CVW'(node_count[NAW-1:0])}
                                : {1'b1, CVW'(in_sym & SYM_MASK)};
            if (link) begin
              zero_we = ~top_slot;
              one_we  = top_slot;
            end else if (!in_bit) begin
              root_leaf_next = 1'b1;
              root_sym_next  = in_sym & SYM_MASK;
            end
            if (in_bit) begin
              top_idx_next  = node_count[NAW-1:0];
              top_slot_next = 1'b0;
              sp_next       = sp_pop + SPW'(1);
              stk_we        = link & ~pop;
            end else begin
              sp_next = sp_pop;
              if (pop) begin
                top_idx_next  = second;
                top_slot_next = 1'b1;
              end else if (link) begin
                top_slot_next = 1'b1;
              end
            end
            node_count_next = node_count + NCW'(1);
            complete_next   = (sp_next == '0);
          end
        end
        htd_pkg::OP_MSG: begin
          s1_valid_next = 1'b1;
          if (!complete) begin
            s1_status_next = htd_pkg::ST_INCOMPLETE;
          end else if (root_leaf) begin
            s1_sym_next = root_sym;
          end else begin
            s1_kind_next = htd_pkg::S1_WALK;
          end
        end
        default: ;
      endcase
    end
  end

  assign stk_raddr_full = sp_next - SPW'(2);
  assign stk_waddr_full = sp - SPW'(1);

  always_ff @(posedge clk) begin
    if (zero_we) begin
      node_zero[top_idx] <= node_wdata;
    end
    rd_zero <= node_zero[walk_cur];
  end

  always_ff @(posedge clk) begin
    if (one_we) begin
      node_one[top_idx] <= node_wdata;
    end
    rd_one <= node_one[walk_cur];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr_full[SAW-1:0]] <= top_idx;
    end
    stk_rd <= stack_mem[stk_raddr_full[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      sp         <= '0;
      complete   <= 1'b0;
      root_leaf  <= 1'b0;
      walk       <= '0;
      fwd_valid  <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      node_count <= node_count_next;
      sp         <= sp_next;
      complete   <= complete_next;
      root_leaf  <= root_leaf_next;
      walk       <= walk_next;
      fwd_valid  <= stk_we;
      s1_valid   <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    root_sym  <= root_sym_next;
    top_idx   <= top_idx_next;
    top_slot  <= top_slot_next;
    fwd_idx   <= top_idx;
    s1_kind   <= s1_kind_next;
    s1_bit    <= in_bit;
    s1_sym    <= s1_sym_next;
    s1_status <= s1_status_next;
  end

  // output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (m_fire) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      q_count <= q_count + (QAW + 1)'(res_valid) - (QAW + 1)'(m_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_sym[wr_ptr]    <= res_sym;
      q_status[wr_ptr] <= res_status;
    end
  end

endmodule

// ===== rtl/core/htd_checker.sv =====
// ----------------------------------------------------------------------------
// htd_checker
// Port-level checks of the Huffman tree decoder, bound to the top level.
// ----------------------------------------------------------------------------
module htd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [htd_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [htd_pkg::USER_W-1:0]     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [htd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [htd_pkg::USER_W-1:0]     m_tuser
);

  localparam int SYM_W = htd_pkg::SYM_W;

  // no result left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result visible right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // error results carry no symbol and padding stays clear
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != htd_pkg::ST_SYMBOL) |-> (m_tdata[SYM_W-1:0] == '0))
    else $error("error result with a symbol");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == htd_pkg::ST_SYMBOL) || (m_tuser == htd_pkg::ST_INCOMPLETE) ||
                 (m_tuser == htd_pkg::ST_MALFORMED))
    else $error("unknown status code");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[htd_pkg::OUT_DATA_W-1:SYM_W] == '0))
    else $error("output padding not zero");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (.*);
